// ----- hw/rtl/differential_drive_odometry_unit_macros.svh -----
// Assertion macros for the differential drive odometry unit.
// Used by differential_drive_odometry_unit.sv; expects clk and arst_n in scope.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DDO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define DDO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DDO_ASSERT_IMP(lbl, ante, cons, msg)
`define DDO_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/ddo_pkg.sv -----
// Package for the differential drive odometry unit: widths, codes, CORDIC table.
// No dependencies.
package ddo_pkg;

	localparam int COUNT_WIDTH  = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam int IT_W         = 5;
	localparam int CFG_W        = 24;
	localparam int A_W          = COUNT_WIDTH + 25;
	localparam int LO_W         = 24;
	localparam int HI_W         = A_W - LO_W;
	localparam int MA_W         = (HI_W > LO_W) ? HI_W : LO_W;
	localparam int MB_W         = 32;
	localparam int ACC_W        = A_W + MB_W;
	localparam int CR_W         = 34;

	localparam int APB_ADDR_W = 4;
	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 160;

	localparam logic signed [CR_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	localparam logic [1:0] REG_LPC = 2'd0;
	localparam logic [1:0] REG_APC = 2'd1;
	localparam logic [1:0] REG_RS  = 2'd2;

	typedef enum logic [1:0] {MODE_RIGHT, MODE_LEFT, MODE_TICK, MODE_POSE} mode_t;
	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CINIT, ST_CORDIC, ST_FIN} state_t;
	typedef enum logic [2:0] {OP_P, OP_T, OP_X, OP_Y, OP_V, OP_W} op_t;
	typedef enum logic [1:0] {PH_LO, PH_HI, PH_COMMIT} ph_t;

	function automatic logic [29:0] atan_at(input logic [IT_W-1:0] i);
		unique case (i)
			5'd0:  return 30'h20000000;
			5'd1:  return 30'h12E4051E;
			5'd2:  return 30'h09FB385B;
			5'd3:  return 30'h051111D4;
			5'd4:  return 30'h028B0D43;
			5'd5:  return 30'h0145D7E1;
			5'd6:  return 30'h00A2F61E;
			5'd7:  return 30'h00517C55;
			5'd8:  return 30'h0028BE53;
			5'd9:  return 30'h00145F2F;
			5'd10: return 30'h000A2F98;
			5'd11: return 30'h000517CC;
			5'd12: return 30'h00028BE6;
			5'd13: return 30'h000145F3;
			5'd14: return 30'h0000A2FA;
			5'd15: return 30'h0000517D;
			5'd16: return 30'h000028BE;
			5'd17: return 30'h0000145F;
			5'd18: return 30'h00000A30;
			5'd19: return 30'h00000518;
			5'd20: return 30'h0000028C;
			5'd21: return 30'h00000146;
			5'd22: return 30'h000000A3;
			5'd23: return 30'h00000051;
			5'd24: return 30'h00000029;
			5'd25: return 30'h00000014;
			5'd26: return 30'h0000000A;
			5'd27: return 30'h00000005;
			5'd28: return 30'h00000003;
			5'd29: return 30'h00000001;
			5'd30: return 30'h00000001;
			default: return 30'h00000000;
		endcase
	endfunction

	function automatic logic [31:0] sat32(input logic [ACC_W-1:0] r, input logic neg);
		logic [31:0] n;
		n = ~r[31:0] + 32'd1;
		if (!neg) begin
			return (r > ACC_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : r[31:0];
		end
		return (r > ACC_W'(33'h080000000)) ? 32'h80000000 : n;
	endfunction

	function automatic logic signed [COUNT_WIDTH-1:0] cnt_step(
		input logic signed [COUNT_WIDTH-1:0] c, input logic up);
		if (up) begin
			return (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
		end
		return (c == CNT_MIN) ? c : c - COUNT_WIDTH'(1);
	endfunction

endpackage

// ----- hw/rtl/differential_drive_odometry_unit.sv -----
// Differential drive odometry with midpoint heading, one shared multiplier and CORDIC.
// Depends on ddo_pkg and differential_drive_odometry_unit_macros.svh.
//
// channel  dir  fields
// s_axis   in   tuser: mode, phase_b; tdata: new_x, new_y, new_heading
// m_axis   out  tdata: x_position, y_position, heading, linear_speed, angular_rate
// apb      cfg  length_per_count @0x0, angle_per_count @0x4, rate_scale @0x8
//
// Edge and set pose items go straight to finish. Control tick: six multiplies in
// low, high and commit steps on a 24x32 multiplier, plus one CORDIC iteration per cycle.
// One item in flight; s_axis_tready is low until the result is in the output register.
// The output register holds a result while m_axis_tready is low.
// Reset clears counts, pose and rates and loads register defaults.
`include "differential_drive_odometry_unit_macros.svh"
module differential_drive_odometry_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ddo_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] new_x, [63:32] new_y, [95:64] new_heading
	input  logic [ddo_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [1:0] mode, [2] phase_b
	input  logic [ddo_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] x_position, [63:32] y_position, [95:64] heading,
	// [127:96] linear_speed, [159:128] angular_rate
	output logic [ddo_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import ddo_pkg::*;

	logic [CFG_W-1:0] lpc_q, apc_q, rs_q;
	logic signed [COUNT_WIDTH-1:0] left_q, right_q;
	logic [31:0] pos_x_q, pos_y_q, head_q, speed_q, rate_q;
	state_t state_q, state_d;
	op_t op_q;
	ph_t ph_q;
	logic [IT_W-1:0] it_q;
	logic [ACC_W-1:0] acc_q;
	logic [A_W-1:0] p_mag_q, t_mag_q;
	logic p_neg_q, t_neg_q, flip_q;
	logic signed [CR_W-1:0] cx_q, cy_q, cz_q;
	logic [OUT_DATA_W-1:0] out_q;
	logic mvalid_q;

	logic in_xfer, cfg_wr, out_load, cordic_last;
	mode_t in_mode;
	logic signed [COUNT_WIDTH:0] sum_s, dif_s;
	logic [COUNT_WIDTH:0] s_mag, d_mag;
	logic signed [CR_W-1:0] cs_s, sn_s, xs, ys, at;
	logic [31:0] cs_mag, sn_mag, pr, dpos, mid, ang, ang2;
	logic dpos_neg;
	logic [A_W-1:0] a_op;
	logic [MB_W-1:0] b_op;
	logic [MA_W-1:0] ma;
	logic [MA_W+MB_W-1:0] pp;
	logic [A_W:0] t_s;

	assign pready        = 1'b1;
	assign cfg_wr        = psel & penable & pwrite & pready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid & s_axis_tready;
	assign in_mode       = mode_t'(s_axis_tuser[1:0]);
	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = out_q;
	assign out_load      = (state_q == ST_FIN) && (!mvalid_q || m_axis_tready);
	assign cordic_last   = (it_q == IT_W'(CORDIC_N - 1));

	always_comb begin
		unique case (paddr[3:2])
			REG_LPC: prdata = {8'd0, lpc_q};
			REG_APC: prdata = {8'd0, apc_q};
			REG_RS:  prdata = {8'd0, rs_q};
			default: prdata = 32'd0;
		endcase
	end

	// operand magnitudes and signs
	assign sum_s  = {left_q[COUNT_WIDTH-1], left_q} + {right_q[COUNT_WIDTH-1], right_q};
	assign dif_s  = {right_q[COUNT_WIDTH-1], right_q} - {left_q[COUNT_WIDTH-1], left_q};
	assign s_mag  = sum_s[COUNT_WIDTH] ? (~sum_s + 1'b1) : sum_s;
	assign d_mag  = dif_s[COUNT_WIDTH] ? (~dif_s + 1'b1) : dif_s;
	assign cs_s   = flip_q ? -cx_q : cx_q;
	assign sn_s   = flip_q ? -cy_q : cy_q;
	assign cs_mag = cs_s[CR_W-1] ? 32'(-cs_s) : 32'(cs_s);
	assign sn_mag = sn_s[CR_W-1] ? 32'(-sn_s) : 32'(sn_s);

	always_comb begin
		unique case (op_q)
			OP_P: begin a_op = A_W'(s_mag); b_op = MB_W'(lpc_q); end
			OP_T: begin a_op = A_W'(d_mag); b_op = MB_W'(apc_q); end
			OP_X: begin a_op = p_mag_q; b_op = cs_mag; end
			OP_Y: begin a_op = p_mag_q; b_op = sn_mag; end
			OP_V: begin a_op = p_mag_q; b_op = MB_W'(rs_q); end
			default: begin a_op = t_mag_q; b_op = MB_W'(rs_q); end
		endcase
	end

	assign ma = (ph_q == PH_HI) ? MA_W'(a_op[A_W-1:LO_W]) : MA_W'(a_op[LO_W-1:0]);
	assign pp = ma * b_op;

	// position step: |P| * |trig| >> 39, sign applied, wraps
	assign pr       = acc_q[39 +: 32];
	assign dpos_neg = p_neg_q ^ ((op_q == OP_X) ? cs_s[CR_W-1] : sn_s[CR_W-1]);
	assign dpos     = dpos_neg ? (~pr + 32'd1) : pr;

	assign t_s  = t_neg_q ? (~{1'b0, t_mag_q} + 1'b1) : {1'b0, t_mag_q};
	assign mid  = head_q + t_s[32:1];
	assign ang  = mid + 32'h40000000;
	assign ang2 = ang[31] ? (mid + 32'h80000000) : mid;

	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign at = $signed({4'd0, atan_at(it_q)});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (in_mode == MODE_TICK) ? ST_MUL : ST_FIN;
				end
			end
			ST_MUL: begin
				if (ph_q == PH_COMMIT && op_q == OP_T) begin
					state_d = ST_CINIT;
				end else if (ph_q == PH_COMMIT && op_q == OP_W) begin
					state_d = ST_FIN;
				end
			end
			ST_CINIT: state_d = ST_CORDIC;
			ST_CORDIC: begin
				if (cordic_last) begin
					state_d = ST_MUL;
				end
			end
			default: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_P;
			ph_q     <= PH_LO;
			it_q     <= '0;
			lpc_q    <= 24'd65536;
			apc_q    <= 24'd65536;
			rs_q     <= 24'd6553600;
			left_q   <= '0;
			right_q  <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			head_q   <= '0;
			speed_q  <= '0;
			rate_q   <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_LPC: lpc_q <= pwdata[CFG_W-1:0];
					REG_APC: apc_q <= pwdata[CFG_W-1:0];
					REG_RS:  rs_q  <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					op_q <= OP_P;
					ph_q <= PH_LO;
					if (in_xfer) begin
						unique case (in_mode)
							MODE_RIGHT: right_q <= cnt_step(right_q, !s_axis_tuser[2]);
							MODE_LEFT:  left_q  <= cnt_step(left_q, s_axis_tuser[2]);
							MODE_TICK:  ;
							default: begin
								pos_x_q <= s_axis_tdata[31:0];
								pos_y_q <= s_axis_tdata[63:32];
								head_q  <= s_axis_tdata[95:64];
							end
						endcase
					end
				end
				ST_MUL: begin
					unique case (ph_q)
						PH_LO: ph_q <= PH_HI;
						PH_HI: ph_q <= PH_COMMIT;
						default: begin
							ph_q <= PH_LO;
							unique case (op_q)
								OP_P: op_q <= OP_T;
								OP_T: op_q <= OP_X;
								OP_X: begin
									op_q    <= OP_Y;
									pos_x_q <= pos_x_q + dpos;
								end
								OP_Y: begin
									op_q    <= OP_V;
									pos_y_q <= pos_y_q + dpos;
								end
								OP_V: begin
									op_q    <= OP_W;
									speed_q <= sat32(acc_q >> 25, p_neg_q);
								end
								default: begin
									op_q    <= OP_P;
									rate_q  <= sat32(acc_q >> 16, t_neg_q);
									head_q  <= head_q + t_s[31:0];
									left_q  <= '0;
									right_q <= '0;
								end
							endcase
						end
					endcase
				end
				ST_CINIT: it_q <= '0;
				ST_CORDIC: it_q <= it_q + IT_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			if (ph_q == PH_LO) begin
				acc_q <= ACC_W'(pp);
			end else if (ph_q == PH_HI) begin
				acc_q <= acc_q + (ACC_W'(pp) << LO_W);
			end else if (op_q == OP_P) begin
				p_mag_q <= acc_q[A_W-1:0];
				p_neg_q <= sum_s[COUNT_WIDTH];
			end else if (op_q == OP_T) begin
				t_mag_q <= acc_q[A_W-1:0];
				t_neg_q <= dif_s[COUNT_WIDTH];
			end
		end
		if (state_q == ST_CINIT) begin
			flip_q <= ang[31];
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= {{(CR_W-32){ang2[31]}}, ang2};
		end
		if (state_q == ST_CORDIC) begin
			if (!cz_q[CR_W-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end
		end
		if (out_load) begin
			out_q <= {rate_q, speed_q, head_q, pos_y_q, pos_x_q};
		end
	end

	`DDO_ASSERT_NXT(a_cnt_clear, (state_q == ST_MUL) && (op_q == OP_W) && (ph_q == PH_COMMIT), (left_q == '0) && (right_q == '0), "counts not cleared after tick")
	`DDO_ASSERT_IMP(a_valid_src, $rose(mvalid_q), $past(state_q) == ST_FIN, "result raised outside finish")
	`DDO_ASSERT_IMP(a_cordic_it, state_q == ST_CORDIC, it_q <= IT_W'(CORDIC_N - 1), "CORDIC count overrun")
	`DDO_ASSERT_IMP(a_ph_rest, state_q != ST_MUL, ph_q == PH_LO, "multiply phase left mid-op")

endmodule
